FILE: rtl/core/shar_pkg.sv
// Shared types and constants for the SCSI host adapter register block.
package shar_pkg;

    // Event kinds carried on the input tuser
    typedef enum logic [2:0] {
        KIND_HOST_READ   = 3'd0,
        KIND_HOST_WRITE  = 3'd1,
        KIND_SET_PHASE   = 3'd2,
        KIND_SET_BUSY    = 3'd3,
        KIND_SET_REQUEST = 3'd4,
        KIND_PUT_BYTE    = 3'd5,
        KIND_REINIT      = 3'd6
    } kind_t;

    // Host register offsets
    localparam logic [1:0] OFF_DATA   = 2'd0;
    localparam logic [1:0] OFF_STATUS = 2'd1;
    localparam logic [1:0] OFF_SELECT = 2'd2;
    localparam logic [1:0] OFF_IRQ_EN = 2'd3;

    // Status bit positions
    localparam int unsigned ST_CND = 7;
    localparam int unsigned ST_INO = 6;
    localparam int unsigned ST_REQ = 5;
    localparam int unsigned ST_IRQ = 4;
    localparam int unsigned ST_BSY = 1;
    localparam int unsigned ST_MSG = 0;

    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned IN_TUSER_W  = 3;
    localparam int unsigned OUT_TDATA_W = 32;

    typedef struct packed {
        kind_t       kind;
        logic [1:0]  reg_offset;
        logic [7:0]  data_byte;
        logic        msg_flag;
        logic        cmd_flag;
        logic        in_flag;
        logic        level;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] status_byte;
        logic       irq_line;
        logic       ack_flag;
        logic       sel_flag;
        logic [7:0] latched_byte;
    } result_t;

endpackage

FILE: rtl/core/scsi_host_adapter_registers.sv
// Top level of the SCSI host adapter register block.
//
// One input item is an event: a host read or write of one of four register
// offsets (data, status, select, irq enable), or a drive-side update (bus
// phase, busy, request, outgoing byte, reinit). The event kind rides on
// s_axis_tuser; the other fields are packed in s_axis_tdata.
// Every item gives exactly one result item on m_axis: the read value (zero
// unless a read of data or status), then the status byte, IRQ, ACK, SEL and
// the host latch as they stand after the event.
// An accepted item is held in the input register; the update logic feeds the state
// registers and the result register, which both load when the item moves on to the
// result register.
// Throughput: one item per cycle while m_axis_tready stays high; the state update is a
// read-modify-write of the adapter registers.
// Reset (rst_n low, asynchronous) clears all adapter state and drops both
// valid flags.
// When m_axis_tready is low the result register holds; the input register
// still takes one more item, after which s_axis_tready falls until the
// result is taken.
module scsi_host_adapter_registers
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [1:0] reg_offset, [9:2] data_byte, [10] msg_flag, [11] cmd_flag,
    // [12] in_flag, [13] level, [15:14] zero
    input  logic [shar_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [2:0] kind
    input  logic [shar_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] read_data, [15:8] status_byte, [16] irq_line, [17] ack_flag,
    // [18] sel_flag, [26:19] latched_byte, [31:27] zero
    output logic [shar_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    shar_pkg::item_t   in_item_reg;
    shar_pkg::item_t   in_item_next;
    logic              in_valid_reg;
    shar_pkg::result_t out_result_reg;
    shar_pkg::result_t result_next;
    logic              out_valid_reg;
    logic              out_free;
    logic              advance;
    logic              accept;

    // Result register can load when empty or being drained this cycle
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_item_next.kind       = shar_pkg::kind_t'(s_axis_tuser[2:0]);
        in_item_next.reg_offset = s_axis_tdata[1:0];
        in_item_next.data_byte  = s_axis_tdata[9:2];
        in_item_next.msg_flag   = s_axis_tdata[10];
        in_item_next.cmd_flag   = s_axis_tdata[11];
        in_item_next.in_flag    = s_axis_tdata[12];
        in_item_next.level      = s_axis_tdata[13];
    end

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (accept)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= in_item_next;
    end

    // Adapter state and update; commits when the item moves on
    shar_regfile u_regfile
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_item_reg),
        .result (result_next)
    );

    // Result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_result_reg <= result_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0,
                            out_result_reg.latched_byte,
                            out_result_reg.sel_flag,
                            out_result_reg.ack_flag,
                            out_result_reg.irq_line,
                            out_result_reg.status_byte,
                            out_result_reg.read_data};

    // Status bits 3 and 2 never set, IRQ mirrors status bit 4
    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[11:10] == 2'b00)
                          && (m_axis_tdata[16] == m_axis_tdata[12]))
        else $error("status shape broken");

    // Reinit leaves status, ACK and SEL cleared
    a_reinit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_item_reg.kind == shar_pkg::KIND_REINIT)) |=>
            (out_result_reg.status_byte == 8'h00) && !out_result_reg.ack_flag
            && !out_result_reg.sel_flag)
        else $error("reinit did not clear state");

    // Raising request drops ACK
    a_req_clears_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_item_reg.kind == shar_pkg::KIND_SET_REQUEST)
                 && in_item_reg.level) |=>
            !out_result_reg.ack_flag && out_result_reg.status_byte[shar_pkg::ST_REQ])
        else $error("request did not clear ACK");

    // A held input item must not be lost while the output stalls
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg && $stable(in_item_reg))
        else $error("pending item dropped");

endmodule

FILE: rtl/core/shar_regfile.sv
// Adapter register state and its per-item update logic.
module shar_regfile
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  shar_pkg::item_t   item,
    output shar_pkg::result_t result
);

    logic [7:0] status_reg, status_next;
    logic [7:0] bus_data_reg, bus_data_next;
    logic [7:0] host_latch_reg, host_latch_next;
    logic       ack_reg, ack_next;
    logic       sel_reg, sel_next;
    logic       irq_en_reg, irq_en_next;
    logic [7:0] rd;

    always_comb
    begin
        status_next     = status_reg;
        bus_data_next   = bus_data_reg;
        host_latch_next = host_latch_reg;
        ack_next        = ack_reg;
        sel_next        = sel_reg;
        irq_en_next     = irq_en_reg;
        rd              = 8'h00;
        unique case (item.kind)
            shar_pkg::KIND_HOST_READ:
            begin
                unique case (item.reg_offset)
                    shar_pkg::OFF_DATA:
                    begin
                        rd       = bus_data_reg;
                        ack_next = 1'b1;
                    end
                    shar_pkg::OFF_STATUS: rd = status_reg;
                    shar_pkg::OFF_SELECT: rd = 8'h00;
                    shar_pkg::OFF_IRQ_EN: rd = 8'h00;
                    default:              rd = 8'h00;
                endcase
            end
            shar_pkg::KIND_HOST_WRITE:
            begin
                unique case (item.reg_offset)
                    shar_pkg::OFF_DATA:
                    begin
                        host_latch_next = item.data_byte;
                        bus_data_next   = item.data_byte;
                        ack_next        = 1'b1;
                    end
                    shar_pkg::OFF_STATUS: ; // read-only to the host
                    shar_pkg::OFF_SELECT:
                    begin
                        host_latch_next = item.data_byte;
                        sel_next        = 1'b1;
                    end
                    shar_pkg::OFF_IRQ_EN:
                    begin
                        irq_en_next = item.data_byte[0];
                        if (!item.data_byte[0])
                            status_next[shar_pkg::ST_IRQ] = 1'b0;
                        else if (status_reg[shar_pkg::ST_REQ])
                            status_next[shar_pkg::ST_IRQ] = 1'b1;
                    end
                    default: ;
                endcase
            end
            shar_pkg::KIND_SET_PHASE:
            begin
                status_next[shar_pkg::ST_MSG] = item.msg_flag;
                status_next[shar_pkg::ST_CND] = item.cmd_flag;
                status_next[shar_pkg::ST_INO] = item.in_flag;
            end
            shar_pkg::KIND_SET_BUSY:
            begin
                status_next[shar_pkg::ST_BSY] = item.level;
                if (item.level)
                    sel_next = 1'b0;
            end
            shar_pkg::KIND_SET_REQUEST:
            begin
                status_next[shar_pkg::ST_REQ] = item.level;
                if (item.level)
                begin
                    ack_next = 1'b0;
                    if (irq_en_reg)
                        status_next[shar_pkg::ST_IRQ] = 1'b1;
                end
            end
            shar_pkg::KIND_PUT_BYTE: bus_data_next = item.data_byte;
            shar_pkg::KIND_REINIT:
            begin
                status_next = 8'h00;
                ack_next    = 1'b0;
                sel_next    = 1'b0;
                irq_en_next = 1'b0;
            end
            default: ; // unused kind: no change
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg     <= 8'h00;
            bus_data_reg   <= 8'h00;
            host_latch_reg <= 8'h00;
            ack_reg        <= 1'b0;
            sel_reg        <= 1'b0;
            irq_en_reg     <= 1'b0;
        end
        else if (fire)
        begin
            status_reg     <= status_next;
            bus_data_reg   <= bus_data_next;
            host_latch_reg <= host_latch_next;
            ack_reg        <= ack_next;
            sel_reg        <= sel_next;
            irq_en_reg     <= irq_en_next;
        end
    end

    assign result.read_data    = rd;
    assign result.status_byte  = status_next;
    assign result.irq_line     = status_next[shar_pkg::ST_IRQ];
    assign result.ack_flag     = ack_next;
    assign result.sel_flag     = sel_next;
    assign result.latched_byte = host_latch_next;

endmodule

FILE: verif/scsi_host_adapter_registers_tb.sv
// Self-checking testbench for the SCSI host adapter register block.
`timescale 1ns / 1ps

module scsi_host_adapter_registers_tb;

    import shar_pkg::*;

    // Kind code outside the defined events; the block must leave state alone
    localparam logic [2:0] KIND_UNUSED = 3'd7;
    localparam int unsigned RANDOM_ITEMS = 1000;
    localparam int unsigned DRAIN_CYCLES = 10;

    // One event as the host or the drive-side engine issues it
    typedef struct {
        logic [2:0] kind;
        logic [1:0] reg_offset;
        logic [7:0] data_byte;
        logic       msg_flag;
        logic       cmd_flag;
        logic       in_flag;
        logic       level;
    } adapter_event_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_TDATA_W-1:0]    s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0]    s_axis_tuser = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]   m_axis_tdata;

    // Events waiting to be sent, and the results they should produce
    adapter_event_t pending_events[$];
    result_t        expected_results[$];

    // Shadow copy of the adapter registers
    logic [7:0] adapter_status;
    logic [7:0] adapter_bus_data;
    logic [7:0] adapter_latch;
    logic       adapter_ack;
    logic       adapter_sel;
    logic       adapter_irq_en;

    int unsigned    mismatch_count = 0;
    int unsigned    send_gap = 0;
    int unsigned    stall_left = 0;
    adapter_event_t current_event;
    result_t        want;

    scsi_host_adapter_registers DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Mostly no gap, sometimes a short one, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 25);
    endfunction

    // Applies one event to the shadow registers and returns the result item
    function automatic result_t predict_event(adapter_event_t ev);
        result_t r;
        r.read_data = 8'h00;
        case (ev.kind)
            KIND_HOST_READ:
            begin
                if (ev.reg_offset == OFF_DATA)
                begin
                    r.read_data = adapter_bus_data;
                    adapter_ack = 1'b1;
                end
                else if (ev.reg_offset == OFF_STATUS)
                    r.read_data = adapter_status;
            end
            KIND_HOST_WRITE:
            begin
                if (ev.reg_offset == OFF_DATA)
                begin
                    adapter_latch = ev.data_byte;
                    adapter_bus_data = ev.data_byte;
                    adapter_ack = 1'b1;
                end
                else if (ev.reg_offset == OFF_SELECT)
                begin
                    adapter_latch = ev.data_byte;
                    adapter_sel = 1'b1;
                end
                else if (ev.reg_offset == OFF_IRQ_EN)
                begin
                    adapter_irq_en = ev.data_byte[0];
                    // disabling drops IRQ; enabling with REQ pending raises it
                    if (!adapter_irq_en)
                        adapter_status[ST_IRQ] = 1'b0;
                    else if (adapter_status[ST_REQ])
                        adapter_status[ST_IRQ] = 1'b1;
                end
            end
            KIND_SET_PHASE:
            begin
                adapter_status[ST_MSG] = ev.msg_flag;
                adapter_status[ST_CND] = ev.cmd_flag;
                adapter_status[ST_INO] = ev.in_flag;
            end
            KIND_SET_BUSY:
            begin
                adapter_status[ST_BSY] = ev.level;
                if (ev.level)
                    adapter_sel = 1'b0;
            end
            KIND_SET_REQUEST:
            begin
                // lowering REQ leaves IRQ set
                adapter_status[ST_REQ] = ev.level;
                if (ev.level)
                begin
                    adapter_ack = 1'b0;
                    if (adapter_irq_en)
                        adapter_status[ST_IRQ] = 1'b1;
                end
            end
            KIND_PUT_BYTE:
                adapter_bus_data = ev.data_byte;
            KIND_REINIT:
            begin
                adapter_status = 8'h00;
                adapter_ack = 1'b0;
                adapter_sel = 1'b0;
                adapter_irq_en = 1'b0;
            end
            default: ;
        endcase
        r.status_byte = adapter_status;
        r.irq_line = adapter_status[ST_IRQ];
        r.ack_flag = adapter_ack;
        r.sel_flag = adapter_sel;
        r.latched_byte = adapter_latch;
        return r;
    endfunction

    task automatic push_event(input logic [2:0] kind, input logic [1:0] off,
                              input logic [7:0] data, input logic msg, input logic cmd,
                              input logic in_f, input logic lvl);
        adapter_event_t ev;
        ev.kind = kind;
        ev.reg_offset = off;
        ev.data_byte = data;
        ev.msg_flag = msg;
        ev.cmd_flag = cmd;
        ev.in_flag = in_f;
        ev.level = lvl;
        pending_events.push_back(ev);
    endtask

    // Any event at all, fields fully random; reinit and the unused kind kept rare
    task automatic push_noise();
        int unsigned r;
        logic [2:0]  k;
        r = $urandom_range(0, 99);
        if (r < 3)
            k = KIND_UNUSED;
        else if (r < 6)
            k = KIND_REINIT;
        else
            k = 3'($urandom_range(0, 5));
        push_event(k, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
    endtask

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // A plausible bus transfer: select, busy, phase, request, host access, release
    task automatic push_transfer();
        if ($urandom_range(0, 2) == 0)
        begin
            push_event(KIND_HOST_WRITE, OFF_SELECT, rnd_byte(), 1'($urandom),
                       1'($urandom), 1'($urandom), 1'($urandom));
            push_event(KIND_SET_BUSY, 2'($urandom), rnd_byte(), 1'($urandom),
                       1'($urandom), 1'($urandom), 1'b1);
        end
        push_event(KIND_SET_PHASE, 2'($urandom), rnd_byte(), 1'($urandom),
                   1'($urandom), 1'($urandom), 1'($urandom));
        if ($urandom_range(0, 3) == 0)
            push_event(KIND_HOST_WRITE, OFF_IRQ_EN, rnd_byte(), 1'($urandom),
                       1'($urandom), 1'($urandom), 1'($urandom));
        push_event(KIND_PUT_BYTE, 2'($urandom), rnd_byte(), 1'($urandom),
                   1'($urandom), 1'($urandom), 1'($urandom));
        push_event(KIND_SET_REQUEST, 2'($urandom), rnd_byte(), 1'($urandom),
                   1'($urandom), 1'($urandom), 1'b1);
        push_event(KIND_HOST_READ, OFF_STATUS, rnd_byte(), 1'($urandom),
                   1'($urandom), 1'($urandom), 1'($urandom));
        push_event($urandom_range(0, 1) ? KIND_HOST_READ : KIND_HOST_WRITE, OFF_DATA,
                   rnd_byte(), 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
        push_event(KIND_SET_REQUEST, 2'($urandom), rnd_byte(), 1'($urandom),
                   1'($urandom), 1'($urandom), 1'b0);
        if ($urandom_range(0, 1) == 0)
            push_event(KIND_SET_BUSY, 2'($urandom), rnd_byte(), 1'($urandom),
                       1'($urandom), 1'($urandom), 1'b0);
    endtask

    task automatic report_field(input string name, input logic [7:0] exp_v,
                                input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // Driver: presents the next pending item, predicting its result on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(predict_event(current_event));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_events.size() > 0)
                begin
                    current_event = pending_events.pop_front();
                    s_axis_tuser <= current_event.kind;
                    s_axis_tdata <= {2'b00, current_event.level, current_event.in_flag,
                                     current_event.cmd_flag, current_event.msg_flag,
                                     current_event.data_byte, current_event.reg_offset};
                    s_axis_tvalid <= 1'b1;
                    send_gap <= pick_gap();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result item against the oldest expectation, stalls at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result item, expected none, actual %h",
                             $time, m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    report_field("read_data", want.read_data, m_axis_tdata[7:0]);
                    report_field("status_byte", want.status_byte, m_axis_tdata[15:8]);
                    report_field("irq_line", 8'(want.irq_line), 8'(m_axis_tdata[16]));
                    report_field("ack_flag", 8'(want.ack_flag), 8'(m_axis_tdata[17]));
                    report_field("sel_flag", 8'(want.sel_flag), 8'(m_axis_tdata[18]));
                    report_field("latched_byte", want.latched_byte, m_axis_tdata[26:19]);
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < 20)
            begin
                stall_left <= pick_gap();
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        adapter_status = 8'h00;
        adapter_bus_data = 8'h00;
        adapter_latch = 8'h00;
        adapter_ack = 1'b0;
        adapter_sel = 1'b0;
        adapter_irq_en = 1'b0;

        // Directed: reads of all offsets straight after reset
        push_event(KIND_HOST_READ, OFF_DATA, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
        push_event(KIND_HOST_READ, OFF_STATUS, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1);
        push_event(KIND_HOST_READ, OFF_SELECT, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
        push_event(KIND_HOST_READ, OFF_IRQ_EN, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
        // IRQ enable, request raising IRQ, disable and re-enable with REQ pending
        push_event(KIND_HOST_WRITE, OFF_IRQ_EN, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0);
        push_event(KIND_SET_REQUEST, OFF_DATA, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
        push_event(KIND_HOST_READ, OFF_STATUS, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
        push_event(KIND_HOST_WRITE, OFF_IRQ_EN, 8'hFE, 1'b0, 1'b0, 1'b0, 1'b0);
        push_event(KIND_HOST_WRITE, OFF_IRQ_EN, 8'h01, 1'b0, 1'b0, 1'b0, 1'b0);
        // Request dropped: IRQ must stay
        push_event(KIND_SET_REQUEST, OFF_DATA, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
        push_event(KIND_HOST_WRITE, OFF_DATA, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0);
        // Status write is ignored
        push_event(KIND_HOST_WRITE, OFF_STATUS, 8'hA5, 1'b1, 1'b1, 1'b1, 1'b1);
        // Select, then busy clearing it
        push_event(KIND_HOST_WRITE, OFF_SELECT, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
        push_event(KIND_SET_BUSY, OFF_DATA, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
        push_event(KIND_SET_BUSY, OFF_DATA, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
        push_event(KIND_SET_PHASE, OFF_DATA, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0);
        push_event(KIND_SET_PHASE, OFF_IRQ_EN, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b1);
        push_event(KIND_PUT_BYTE, OFF_DATA, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
        push_event(KIND_PUT_BYTE, OFF_DATA, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0);
        push_event(KIND_HOST_READ, OFF_DATA, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
        // Unused kind changes nothing; reinit keeps the latch and data register
        push_event(KIND_UNUSED, OFF_IRQ_EN, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1);
        push_event(KIND_SET_PHASE, OFF_DATA, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1);
        push_event(KIND_REINIT, OFF_DATA, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
        push_event(KIND_HOST_READ, OFF_DATA, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);

        // Random part: mostly whole transfers, the rest noise
        while (pending_events.size() < RANDOM_ITEMS + 24)
        begin
            if ($urandom_range(0, 9) < 7)
                push_transfer();
            else
                push_noise();
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_events.size() == 0 && !s_axis_tvalid);
        wait (expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS scsi_host_adapter_registers");
        else
            $display("FAIL scsi_host_adapter_registers");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("FAIL scsi_host_adapter_registers");
        $finish;
    end

endmodule

FILE: scsi_host_adapter_registers.f
rtl/core/shar_pkg.sv
rtl/core/shar_regfile.sv
rtl/core/scsi_host_adapter_registers.sv
verif/scsi_host_adapter_registers_tb.sv
